FILE: sv/ffsa_pkg.sv
// Shared types and codes for the first-free slot allocator.
// No dependencies; imported by the slot map and the top level.
`default_nettype none

package ffsa_pkg;

  localparam int unsigned SLOT_W = 7;

  // request function codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // result status codes
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [SLOT_W-1:0] granted_slot;
    logic [SLOT_W-1:0] highest_used;
    logic              any_used;
  } rsp_t;

endpackage

`default_nettype wire

FILE: sv/ffsa_prio_enc.sv
// Log-depth priority encoder tree, lowest-first or highest-first.
// Standalone; used by ffsa_slot_map.
`default_nettype none

module ffsa_prio_enc #(
  parameter int unsigned WIDTH     = 128,
  parameter bit          LOW_FIRST = 1'b1,
  localparam int unsigned IDX_W    = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
  input  logic [WIDTH-1:0] req_i,
  output logic             found_o,
  output logic [IDX_W-1:0] idx_o
);

  localparam int unsigned LEAVES = 1 << IDX_W;
  localparam int unsigned NODES  = 2 * LEAVES - 1;

  // heap layout: node k has children 2k+1 and 2k+2, leaves from LEAVES-1
  logic             node_vld [NODES];
  logic [IDX_W-1:0] node_idx [NODES];

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < WIDTH) begin : g_real
      assign node_vld[LEAVES-1+i] = req_i[i];
    end else begin : g_pad
      assign node_vld[LEAVES-1+i] = 1'b0;
    end
    assign node_idx[LEAVES-1+i] = IDX_W'(i);
  end

  for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
    logic take_right;
    assign take_right  = LOW_FIRST ? !node_vld[2*k+1] : node_vld[2*k+2];
    assign node_vld[k] = node_vld[2*k+1] | node_vld[2*k+2];
    assign node_idx[k] = take_right ? node_idx[2*k+2] : node_idx[2*k+1];
  end

  assign found_o = node_vld[0];
  assign idx_o   = node_idx[0];

endmodule

`default_nettype wire

FILE: sv/ffsa_slot_map.sv
// Used-bit map, highest-used mark and the single-pass next-state logic.
// Depends on ffsa_pkg and ffsa_prio_enc.
`default_nettype none

module ffsa_slot_map
  import ffsa_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  req_t req_i,
  output rsp_t rsp_o
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [SLOT_COUNT-1:0] map_q, map_d;
  logic [IDX_W-1:0]      mark_q, mark_d;

  logic [SLOT_COUNT-1:0] grant_oh, slot_oh, map_cleared;
  logic                  free_found, top_found;
  logic [IDX_W-1:0]      free_idx, top_idx;
  logic                  is_mark;
  logic [31:0]           grant_ext, mark_ext;
  logic                  status;
  logic [IDX_W-1:0]      granted;

  ffsa_prio_enc #(.WIDTH(SLOT_COUNT), .LOW_FIRST(1'b1)) u_free_enc (
    .req_i  (~map_q),
    .found_o(free_found),
    .idx_o  (free_idx)
  );

  ffsa_prio_enc #(.WIDTH(SLOT_COUNT), .LOW_FIRST(1'b0)) u_top_enc (
    .req_i  (map_cleared),
    .found_o(top_found),
    .idx_o  (top_idx)
  );

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      grant_oh[i] = (32'(free_idx) == i);
      slot_oh[i]  = (32'(req_i.slot) == i);
    end
  end

  assign map_cleared = map_q & ~slot_oh;
  // out-of-pool slots match no bit of slot_oh, so they are ignored
  assign is_mark = (32'(mark_q) == 32'(req_i.slot)) && (|slot_oh);

  always_comb begin
    map_d   = map_q;
    mark_d  = mark_q;
    status  = STATUS_DONE;
    granted = '0;
    case (req_i.func)
      FUNC_ALLOC: begin
        if (free_found) begin
          map_d   = map_q | grant_oh;
          granted = free_idx;
          if (free_idx > mark_q) begin
            mark_d = free_idx;
          end
        end else begin
          status = STATUS_FULL;
        end
      end
      FUNC_FREE: begin
        map_d = map_cleared;
        if (is_mark) begin
          mark_d = top_found ? top_idx : '0;
        end
      end
      default: begin
        map_d = map_q;
      end
    endcase
  end

  assign grant_ext = 32'(granted);
  assign mark_ext  = 32'(mark_d);

  assign rsp_o.status       = status;
  assign rsp_o.granted_slot = grant_ext[SLOT_W-1:0];
  assign rsp_o.highest_used = mark_ext[SLOT_W-1:0];
  assign rsp_o.any_used     = |map_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q  <= '0;
      mark_q <= '0;
    end else if (step_i) begin
      map_q  <= map_d;
      mark_q <= mark_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/first_free_slot_allocator_core.sv
// First-free slot allocator: top level with input and result registers.
// Each result is captured in the result register as its item leaves the input register.
// Throughput: one item per cycle while out_ready_i does not stall the result register.
// Reset (async, active low): every slot free, highest mark 0, both registers empty.
// Depends on ffsa_pkg and ffsa_slot_map.
`default_nettype none

module first_free_slot_allocator_core
  import ffsa_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  // request channel
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  // result channel
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  // input register
  logic in_vld_q;
  req_t in_req_q;

  // result register
  logic out_vld_q;
  rsp_t out_rsp_q;

  logic res_free;   // result register can take a new item this cycle
  logic step;       // the held item is processed and its state update commits
  rsp_t step_rsp;

  assign res_free   = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && res_free;
  // input register frees up whenever its item moves on, so back-to-back items flow
  assign in_ready_o = !in_vld_q || res_free;

  // map and mark update in the same cycle as the result is captured,
  // so the next held item already sees the new state
  ffsa_slot_map #(.SLOT_COUNT(SLOT_COUNT)) u_map (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .req_i (in_req_q),
    .rsp_o (step_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_req_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_free) begin
      out_vld_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_rsp_q <= step_rsp;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_rsp_q;

endmodule

`default_nettype wire

FILE: tb/first_free_slot_allocator_core_test.sv
// Self-checking testbench for first_free_slot_allocator_core: directed corner items, then
// fill, drain and mixed bursts checked against a bitmap predictor of the allocator.
// Depends on ffsa_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module first_free_slot_allocator_core_test;
  import ffsa_pkg::*;

  localparam int unsigned POOL        = 128;
  localparam int unsigned ITEM_TARGET = 1950;
  localparam int unsigned HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int unsigned TAIL_CYCLES = 10;    // idle tail after the final drain

  // Kinds of random burst: each biases the allocate/free mix differently.
  typedef enum int {
    BURST_FILL,
    BURST_DRAIN,
    BURST_EVEN
  } burst_kind_e;

  // Tracks the slot map the block should hold and the results still due from it.
  class slot_ledger;
    bit [POOL-1:0] in_use;
    int unsigned   top_mark;
    rsp_t          due_q[$];
    int unsigned   bad;
    int unsigned   allocs;
    int unsigned   frees;
    int unsigned   refusals;
    int unsigned   empties;

    function new();
      in_use   = '0;
      top_mark = 0;
      bad      = 0;
      allocs   = 0;
      frees    = 0;
      refusals = 0;
      empties  = 0;
    endfunction

    function int unsigned highest_taken();
      int unsigned top;
      top = 0;
      for (int i = 0; i < POOL; i++)
        if (in_use[i]) top = i;
      return top;
    endfunction

    // Random slot that is in use, or a random slot when none is.
    function int unsigned pick_taken();
      int unsigned start;
      start = $urandom_range(0, POOL - 1);
      for (int k = 0; k < POOL; k++)
        if (in_use[(start + k) % POOL]) return (start + k) % POOL;
      return start;
    endfunction

    function int unsigned outstanding();
      return due_q.size();
    endfunction

    // Apply one accepted request to the map and queue the result it must produce.
    function void note_request(req_t req);
      rsp_t want;
      int   pick;
      want        = '0;
      want.status = STATUS_DONE;
      pick        = -1;
      if (req.func == FUNC_ALLOC) begin
        allocs++;
        for (int i = POOL - 1; i >= 0; i--)
          if (!in_use[i]) pick = i;
        if (pick < 0) begin
          want.status = STATUS_FULL;
          refusals++;
        end else begin
          in_use[pick]      = 1'b1;
          want.granted_slot = pick[SLOT_W-1:0];
          if (pick > top_mark) top_mark = pick;
        end
      end else begin
        frees++;
        if (req.slot < POOL) begin
          in_use[req.slot] = 1'b0;
          if (top_mark == req.slot) top_mark = highest_taken();
        end
      end
      want.highest_used = top_mark[SLOT_W-1:0];
      want.any_used     = |in_use;
      if (!want.any_used) empties++;
      due_q.push_back(want);
    endfunction

    function void compare_field(string what, logic [SLOT_W-1:0] want, logic [SLOT_W-1:0] got);
      if (got !== want) begin
        bad++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (due_q.size() == 0) begin
        bad++;
        $display("%0t: result with none expected, expected none, got %h", $time, got);
        return;
      end
      want = due_q.pop_front();
      compare_field("status", SLOT_W'(want.status), SLOT_W'(got.status));
      compare_field("granted_slot", want.granted_slot, got.granted_slot);
      compare_field("highest_used", want.highest_used, got.highest_used);
      compare_field("any_used", SLOT_W'(want.any_used), SLOT_W'(got.any_used));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;

  slot_ledger ledger;
  bit         hold_off_req;  // set by the sender, cleared by the receiver after the hold

  first_free_slot_allocator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item at the falling edge and hold it until accepted. The ledger is
  // updated right at the accepting edge, so the next item is chosen from an
  // up-to-date map. With gap 0, valid simply stays high for the next item.
  task automatic send_request(input logic func, input logic [SLOT_W-1:0] slot,
                              input int unsigned gap);
    req_t req;
    req.func = func;
    req.slot = slot;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ledger.note_request(req);
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Drop valid and wait until every queued result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk_i);
  endtask

  // One random item shaped by the burst kind. Frees mostly target slots in use
  // so drain bursts really empty the pool; some hit the current mark to force
  // the highest-slot search, the rest land anywhere (free slots included).
  task automatic random_item(input burst_kind_e kind, input bit calm);
    int unsigned alloc_pct;
    int unsigned roll;
    logic [SLOT_W-1:0] slot;
    case (kind)
      BURST_FILL:  alloc_pct = 90;
      BURST_DRAIN: alloc_pct = 15;
      default:     alloc_pct = 50;
    endcase
    roll = $urandom_range(0, 99);
    if (roll < alloc_pct) begin
      slot = SLOT_W'($urandom);  // ignored by the block, still exercised
      send_request(FUNC_ALLOC, slot, calm ? 0 : pick_gap());
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 75)      slot = SLOT_W'(ledger.pick_taken());
      else if (roll < 85) slot = SLOT_W'(ledger.top_mark);
      else                slot = SLOT_W'($urandom);
      send_request(FUNC_FREE, slot, calm ? 0 : pick_gap());
    end
  endtask

  // Receiver: random stalls, calm stretches with ready held high, and one long
  // hold-off on request so the block backs up and drops in_ready_o.
  initial begin
    int unsigned stall_left;
    int unsigned calm_left;
    stall_left  = 0;
    calm_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (calm_left != 0) begin
          calm_left--;
        end else if ($urandom_range(0, 99) < 3) begin
          calm_left = $urandom_range(50, 200);
        end else if ($urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Results are checked at the rising edge, before the block's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) ledger.check_response(out_data_o);
  end

  // Main sequence: reset, directed corners, a fill past capacity, random bursts.
  initial begin
    int unsigned sent;
    int unsigned burst_no;
    int unsigned burst_len;
    burst_kind_e kind;
    bit          calm;

    ledger       = new();
    hold_off_req = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: frees on an empty pool (slot 0 equals the mark, slot 127 all ones),
    // first grants, reuse of a freed hole, freeing the highest slot so the mark
    // falls back, freeing an already free slot, and back down to empty.
    send_request(FUNC_FREE,  7'd0,   pick_gap());
    send_request(FUNC_FREE,  7'd127, pick_gap());
    send_request(FUNC_ALLOC, 7'd127, 0);
    send_request(FUNC_ALLOC, 7'd0,   0);
    send_request(FUNC_ALLOC, 7'd85,  pick_gap());
    send_request(FUNC_FREE,  7'd1,   0);
    send_request(FUNC_ALLOC, 7'd42,  0);
    send_request(FUNC_FREE,  7'd2,   pick_gap());
    send_request(FUNC_FREE,  7'd2,   0);
    send_request(FUNC_FREE,  7'd1,   0);
    send_request(FUNC_FREE,  7'd0,   pick_gap());
    send_request(FUNC_ALLOC, 7'd0,   0);
    send_request(FUNC_FREE,  7'd127, 0);
    send_request(FUNC_FREE,  7'd0,   0);
    drain_results();

    // Fill the whole pool, then ask three more times to hit the full refusal.
    sent = 0;
    while (!(&ledger.in_use)) begin
      send_request(FUNC_ALLOC, SLOT_W'($urandom), pick_gap());
      sent++;
    end
    repeat (3) begin
      send_request(FUNC_ALLOC, SLOT_W'($urandom), pick_gap());
      sent++;
    end
    // Free the top slot of a full pool, then the lowest, then refill both.
    send_request(FUNC_FREE,  7'd127, 0);
    send_request(FUNC_FREE,  7'd0,   0);
    send_request(FUNC_ALLOC, 7'd0,   0);
    send_request(FUNC_ALLOC, 7'd0,   pick_gap());
    sent += 4;

    // Random bursts. Burst 3 runs under the long receiver hold-off; every fourth
    // burst ends with the sender waiting for all results to return.
    burst_no = 0;
    while (sent < ITEM_TARGET) begin
      kind      = burst_kind_e'($urandom_range(0, 2));
      burst_len = $urandom_range(20, 160);
      calm      = ($urandom_range(0, 3) == 0);
      if (burst_no == 3) hold_off_req = 1'b1;
      repeat (burst_len) begin
        random_item(kind, calm);
        sent++;
      end
      if (burst_no % 4 == 1) drain_results();
      burst_no++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d allocates (%0d refused on a full pool) and %0d frees;",
             ledger.allocs, ledger.refusals, ledger.frees);
    $display("%0d results reported an empty pool, %0d bursts after the directed part.",
             ledger.empties, burst_no);
    if (ledger.bad == 0 && ledger.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      if (ledger.outstanding() != 0)
        $display("%0t: results left over, expected 0, got %0d", $time, ledger.outstanding());
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
sv/ffsa_pkg.sv
sv/ffsa_prio_enc.sv
sv/ffsa_slot_map.sv
sv/first_free_slot_allocator_core.sv
tb/first_free_slot_allocator_core_test.sv
